// ----- hw/rtl/sroi_pkg.sv -----
// ----------------------------------------------------------------------------
// sroi_pkg
// shared types and constants of the sparse row offset index
// ----------------------------------------------------------------------------
package sroi_pkg;

  localparam int MAX_COLUMNS      = 16;
  localparam int MARKS_PER_COLUMN = 1024;
  localparam int COL_W            = $clog2(MAX_COLUMNS);
  localparam int SLOT_W           = $clog2(MARKS_PER_COLUMN);
  localparam int USED_W           = SLOT_W + 1;
  localparam int MARK_DEPTH       = MAX_COLUMNS * MARKS_PER_COLUMN;
  localparam int MARK_ADDR_W      = COL_W + SLOT_W;
  localparam int BYTES_W          = 48;
  localparam int ROW_W            = 32;
  localparam int SINCE_W          = 32;
  localparam int LEN_W            = 16;
  localparam int GAP_W            = 24;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(262144);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [ROW_W-1:0]   rows;
    logic [SINCE_W-1:0] since;
    logic [USED_W-1:0]  used;
  } col_state_t;

  typedef struct packed {
    logic [BYTES_W-1:0] offset;
    logic [ROW_W-1:0]   row;
  } mark_t;

  typedef struct packed {
    logic               hit;
    logic               full;
    logic [SLOT_W-1:0]  slot;
    logic [BYTES_W-1:0] offset;
    logic [ROW_W-1:0]   first;
    logic [ROW_W-1:0]   largest;
  } app_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_SCAN
  } state_t;

endpackage

// ----- hw/rtl/sroi_ram.sv -----
// ----------------------------------------------------------------------------
// sroi_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sroi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/sroi_append.sv -----
// ----------------------------------------------------------------------------
// sroi_append
// next column state and mark decision for one appended field
// ----------------------------------------------------------------------------
module sroi_append (
  input  sroi_pkg::col_state_t              col_cur,
  input  logic [sroi_pkg::LEN_W-1:0]        field_len,
  input  logic [sroi_pkg::GAP_W-1:0]        gap,
  input  logic [sroi_pkg::ROW_W-1:0]        largest,
  output sroi_pkg::col_state_t              col_next,
  output sroi_pkg::app_res_t                res
);
  import sroi_pkg::*;

  logic [LEN_W:0]     written;
  logic [SINCE_W:0]   since_sum;
  logic [SINCE_W:0]   since_new;
  logic               want;
  logic               room;
  logic               hit;
  logic [ROW_W-1:0]   rows_new;

  always_comb begin
    written   = {1'b0, field_len} + (LEN_W + 1)'(1);
    since_sum = (SINCE_W + 1)'(col_cur.since) + (SINCE_W + 1)'(written);
    want      = since_sum > (SINCE_W + 1)'(gap);
    room      = col_cur.used < USED_W'(MARKS_PER_COLUMN);
    hit       = want && room;
    since_new = hit ? (SINCE_W + 1)'(written) : since_sum;
    rows_new  = col_cur.rows + ROW_W'(1);

    col_next.bytes = col_cur.bytes + BYTES_W'(written);
    col_next.rows  = rows_new;
    col_next.since = since_new[SINCE_W] ? '1 : since_new[SINCE_W-1:0];
    col_next.used  = hit ? col_cur.used + USED_W'(1) : col_cur.used;

    res.hit     = hit;
    res.full    = want && !room;
    res.slot    = hit ? col_cur.used[SLOT_W-1:0] : '0;
    res.offset  = hit ? col_cur.bytes : '0;
    res.first   = hit ? col_cur.rows : '0;
    res.largest = (rows_new > largest) ? rows_new : largest;
  end

endmodule

// ----- hw/rtl/sparse_row_offset_index.sv -----
// ----------------------------------------------------------------------------
// sparse_row_offset_index
// per-column sparse index of byte offsets and row numbers, one request at a time
// ----------------------------------------------------------------------------
// append: column ram read, then the update and the result register load
// lookup: column ram read, then marks read newest first until one is at or
//   below the row or none is left; one mark ram read per cycle unless stalled
// next request is taken the cycle after the result is loaded, never while one
//   is in flight; a held output register stalls the update and the scan
// reset: column counters read as zero through per-column valid bits, mark
//   tables are not cleared, the gap returns to 262144; no clearing pass
module sparse_row_offset_index (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sroi_pkg::GAP_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [sroi_pkg::COL_W-1:0]     column,
  input  logic [sroi_pkg::LEN_W-1:0]     field_len,
  input  logic [sroi_pkg::ROW_W-1:0]     row_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [sroi_pkg::SLOT_W-1:0]    slot,
  output logic [sroi_pkg::BYTES_W-1:0]   byte_offset,
  output logic [sroi_pkg::ROW_W-1:0]     first_row,
  output logic                           table_full,
  output logic [sroi_pkg::ROW_W-1:0]     row_total
);
  import sroi_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic                   op_q;
  logic [COL_W-1:0]       col_q;
  logic [LEN_W-1:0]       len_q;
  logic [ROW_W-1:0]       row_q;
  logic [GAP_W-1:0]       gap;
  logic [ROW_W-1:0]       largest;
  logic [MAX_COLUMNS-1:0] col_valid;
  logic [SLOT_W-1:0]      scan_slot;

  logic                   accept;
  logic                   out_free;
  col_state_t             col_rd_data;
  col_state_t             col_cur;
  col_state_t             col_next;
  app_res_t               app;
  logic [USED_W-1:0]      used_dec;
  mark_t                  mark_rd_data;
  mark_t                  mark_wr_data;
  logic                   found;

  logic                   col_wr_en;
  logic                   mark_wr_en;
  logic                   mark_rd_en;
  logic [SLOT_W-1:0]      mark_rd_slot;
  logic                   out_load;
  logic                   res_hit;
  logic [SLOT_W-1:0]      res_slot;
  logic [BYTES_W-1:0]     res_offset;
  logic [ROW_W-1:0]       res_first;
  logic                   res_full;
  logic [ROW_W-1:0]       res_total;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign col_cur      = col_valid[col_q] ? col_rd_data : '0;
  assign used_dec     = col_cur.used - USED_W'(1);
  assign found        = mark_rd_data.row <= row_q;
  assign mark_wr_data = '{offset: col_cur.bytes, row: col_cur.rows};

  sroi_ram #(
    .WIDTH ($bits(col_state_t)),
    .DEPTH (MAX_COLUMNS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (col_wr_en),
    .wr_addr (col_q),
    .wr_data (col_next),
    .rd_en   (accept),
    .rd_addr (column),
    .rd_data (col_rd_data)
  );

  sroi_ram #(
    .WIDTH ($bits(mark_t)),
    .DEPTH (MARK_DEPTH)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (mark_wr_en),
    .wr_addr ({col_q, col_cur.used[SLOT_W-1:0]}),
    .wr_data (mark_wr_data),
    .rd_en   (mark_rd_en),
    .rd_addr ({col_q, mark_rd_slot}),
    .rd_data (mark_rd_data)
  );

  sroi_append u_append (
    .col_cur   (col_cur),
    .field_len (len_q),
    .gap       (gap),
    .largest   (largest),
    .col_next  (col_next),
    .res       (app)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (op_q == OP_LOOKUP && col_cur.used != '0) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free && (found || scan_slot == '0)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and result selection
  always_comb begin
    col_wr_en    = 1'b0;
    mark_wr_en   = 1'b0;
    mark_rd_en   = 1'b0;
    mark_rd_slot = scan_slot - SLOT_W'(1);
    out_load     = 1'b0;
    res_hit      = 1'b0;
    res_slot     = '0;
    res_offset   = '0;
    res_first    = '0;
    res_full     = 1'b0;
    res_total    = largest;
    case (state)
      S_IDLE: begin
      end
      S_CALC: begin
        if (op_q == OP_APPEND) begin
          col_wr_en  = out_free;
          mark_wr_en = out_free && app.hit;
          out_load   = out_free;
          res_hit    = app.hit;
          res_slot   = app.slot;
          res_offset = app.offset;
          res_first  = app.first;
          res_full   = app.full;
          res_total  = app.largest;
        end else if (col_cur.used != '0) begin
          mark_rd_en   = 1'b1;
          mark_rd_slot = used_dec[SLOT_W-1:0];
        end else begin
          out_load = out_free;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (found) begin
            out_load   = 1'b1;
            res_hit    = 1'b1;
            res_slot   = scan_slot;
            res_offset = mark_rd_data.offset;
            res_first  = mark_rd_data.row;
          end else if (scan_slot == '0) begin
            out_load = 1'b1;
          end else begin
            mark_rd_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap       <= GAP_RESET;
      largest   <= '0;
      col_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        gap <= cfg_data;
      end
      if (col_wr_en) begin
        largest          <= app.largest;
        col_valid[col_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      col_q <= column;
      len_q <= field_len;
      row_q <= row_number;
    end
    if (mark_rd_en) begin
      scan_slot <= mark_rd_slot;
    end
    if (out_load) begin
      hit         <= res_hit;
      slot        <= res_slot;
      byte_offset <= res_offset;
      first_row   <= res_first;
      table_full  <= res_full;
      row_total   <= res_total;
    end
  end

  a_hit_or_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && table_full))
    else $error("result reports both a recorded mark and a full table");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    mark_wr_en |-> !col_cur.used[SLOT_W])
    else $error("mark written beyond the column's slots");

  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mark_rd_en) |=> scan_slot == $past(scan_slot) - SLOT_W'(1))
    else $error("lookup scan skipped a slot");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC && !in_ready))
    else $error("request not taken into the column read step");

endmodule

// ----- dv/sparse_row_offset_index_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_offset_index_chk
// Passive checker for the sparse row offset index. It follows the gap
// register, the request channel and the result channel. It keeps its own
// per-column byte and row counters and its own mark tables, and predicts the
// result of every accepted request. Each accepted result is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_row_offset_index_chk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sroi_pkg::GAP_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         operation,
  input  logic [sroi_pkg::COL_W-1:0]   column,
  input  logic [sroi_pkg::LEN_W-1:0]   field_len,
  input  logic [sroi_pkg::ROW_W-1:0]   row_number,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         hit,
  input  logic [sroi_pkg::SLOT_W-1:0]  slot,
  input  logic [sroi_pkg::BYTES_W-1:0] byte_offset,
  input  logic [sroi_pkg::ROW_W-1:0]   first_row,
  input  logic                         table_full,
  input  logic [sroi_pkg::ROW_W-1:0]   row_total,
  output int                           fail_count,
  output int                           outstanding,
  output int                           marks_made,
  output int                           marks_dropped,
  output int                           rows_found,
  output int                           rows_missed
);
  import sroi_pkg::*;

  logic [GAP_W-1:0]   gap_setting;
  logic [BYTES_W-1:0] byte_count   [MAX_COLUMNS];
  logic [ROW_W-1:0]   row_count    [MAX_COLUMNS];
  logic [SINCE_W-1:0] unmarked     [MAX_COLUMNS];
  int                 marks_held   [MAX_COLUMNS];
  logic [BYTES_W-1:0] mark_offsets [MAX_COLUMNS][MARKS_PER_COLUMN];
  logic [ROW_W-1:0]   mark_rows    [MAX_COLUMNS][MARKS_PER_COLUMN];
  logic [ROW_W-1:0]   widest_rows;
  app_res_t           expected_replies [$];
  int                 errors    = 0;
  int                 n_marks   = 0;
  int                 n_dropped = 0;
  int                 n_found   = 0;
  int                 n_missed  = 0;

  function automatic app_res_t predict_reply(input logic op, input logic [COL_W-1:0] col,
                                             input logic [LEN_W-1:0] len,
                                             input logic [ROW_W-1:0] row);
    app_res_t         reply;
    logic [LEN_W:0]   written;
    logic [SINCE_W:0] span;
    int               k;
    reply = '0;
    if (op == OP_APPEND) begin
      written = {1'b0, len} + (LEN_W+1)'(1);
      span    = {1'b0, unmarked[col]} + (SINCE_W+1)'(written);
      if (span > (SINCE_W+1)'(gap_setting)) begin
        if (marks_held[col] < MARKS_PER_COLUMN) begin
          mark_offsets[col][marks_held[col]] = byte_count[col];
          mark_rows[col][marks_held[col]]    = row_count[col];
          reply.hit    = 1'b1;
          reply.slot   = SLOT_W'(marks_held[col]);
          reply.offset = byte_count[col];
          reply.first  = row_count[col];
          marks_held[col]++;
          span = (SINCE_W+1)'(written);
          n_marks++;
        end else begin
          // no free slot: mark dropped, span kept so the next append asks again
          reply.full = 1'b1;
          n_dropped++;
        end
      end
      unmarked[col]   = span[SINCE_W] ? '1 : span[SINCE_W-1:0];
      byte_count[col] = byte_count[col] + BYTES_W'(written);
      row_count[col]  = row_count[col] + ROW_W'(1);
      if (row_count[col] > widest_rows) widest_rows = row_count[col];
    end else begin
      // newest mark first, stop at the first one at or below the row
      k = marks_held[col];
      while (k > 0 && !reply.hit) begin
        k--;
        if (mark_rows[col][k] <= row) begin
          reply.hit    = 1'b1;
          reply.slot   = SLOT_W'(k);
          reply.offset = mark_offsets[col][k];
          reply.first  = mark_rows[col][k];
        end
      end
      if (reply.hit) n_found++;
      else n_missed++;
    end
    reply.largest = widest_rows;
    return reply;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    app_res_t want;
    if (rst) begin
      gap_setting = GAP_RESET;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        byte_count[c] = '0;
        row_count[c]  = '0;
        unmarked[c]   = '0;
        marks_held[c] = 0;
      end
      widest_rows = '0;
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) gap_setting = cfg_data;
      if (in_valid && in_ready)
        expected_replies.push_back(predict_reply(operation, column, field_len, row_number));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request outstanding, expected none, actual hit %0b",
                   $time, hit);
        end else begin
          want = expected_replies.pop_front();
          check_field("hit", 64'(want.hit), 64'(hit));
          check_field("slot", 64'(want.slot), 64'(slot));
          check_field("byte_offset", 64'(want.offset), 64'(byte_offset));
          check_field("first_row", 64'(want.first), 64'(first_row));
          check_field("table_full", 64'(want.full), 64'(table_full));
          check_field("row_total", 64'(want.largest), 64'(row_total));
        end
      end
    end
    fail_count    <= errors;
    outstanding   <= expected_replies.size();
    marks_made    <= n_marks;
    marks_dropped <= n_dropped;
    rows_found    <= n_found;
    rows_missed   <= n_missed;
  end

endmodule

// ----- dv/sparse_row_offset_index_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_offset_index_tb
// Stimulus and verdict for the sparse row offset index. A short directed part
// covers empty columns, the reset gap, a zero gap and the largest gap. One
// column is then filled until its mark table overflows. Short random phases
// follow at several gap settings, most with random gaps on both channels and one
// long stall on the result side. The checker beside the block predicts and
// compares.
// ----------------------------------------------------------------------------
module sparse_row_offset_index_tb;
  import sroi_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int FILL_COLUMN = 3;
  localparam int WIDE_COLUMN = 9;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [GAP_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [COL_W-1:0]   column;
  logic [LEN_W-1:0]   field_len;
  logic [ROW_W-1:0]   row_number;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [BYTES_W-1:0] byte_offset;
  logic [ROW_W-1:0]   first_row;
  logic               table_full;
  logic [ROW_W-1:0]   row_total;

  int   fail_count;
  int   outstanding;
  int   marks_made;
  int   marks_dropped;
  int   rows_found;
  int   rows_missed;
  logic calm    = 1'b0;
  logic squeeze = 1'b0;
  int   rows_sent [MAX_COLUMNS];
  int   requests_sent;
  int   gap_writes;

  always #10 clk = ~clk;

  sparse_row_offset_index DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .column     (column),
    .field_len  (field_len),
    .row_number (row_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .slot       (slot),
    .byte_offset(byte_offset),
    .first_row  (first_row),
    .table_full (table_full),
    .row_total  (row_total)
  );

  sparse_row_offset_index_chk index_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .column        (column),
    .field_len     (field_len),
    .row_number    (row_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .byte_offset   (byte_offset),
    .first_row     (first_row),
    .table_full    (table_full),
    .row_total     (row_total),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .marks_made    (marks_made),
    .marks_dropped (marks_dropped),
    .rows_found    (rows_found),
    .rows_missed   (rows_missed)
  );

  task automatic send_request(input logic op, input logic [COL_W-1:0] col,
                              input logic [LEN_W-1:0] len, input logic [ROW_W-1:0] row);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    column     <= col;
    field_len  <= len;
    row_number <= row;
    do @(posedge clk); while (!in_ready);
    if (op == OP_APPEND) rows_sent[col]++;
    requests_sent++;
  endtask

  task automatic random_request(input int focus, input int focus_pct, input int append_pct,
                                input bit long_fields);
    logic             op;
    logic [COL_W-1:0] col;
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] row;
    int               pick;
    op  = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_LOOKUP;
    col = ($urandom_range(0, 99) < focus_pct) ? COL_W'(focus)
                                               : COL_W'($urandom_range(0, MAX_COLUMNS - 1));
    pick = $urandom_range(0, 9);
    if (long_fields) len = LEN_W'($urandom_range(49152, 65535));
    else if (pick < 6) len = LEN_W'($urandom_range(0, 255));
    else if (pick < 9) len = LEN_W'($urandom);
    else len = $urandom_range(0, 1) ? '1 : '0;
    pick = $urandom_range(0, 9);
    if (pick < 6) row = ROW_W'($urandom_range(0, rows_sent[col] + 2));
    else if (pick < 8) row = $urandom;
    else if (pick == 8) row = '0;
    else row = '1;
    send_request(op, col, len, row);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    in_valid <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_writes++;
  endtask

  initial begin : result_sink
    bit squeezed;
    squeezed  = 1'b0;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        // long hold so the block backs up and refuses requests
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles without finishing", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_APPEND;
    column        = '0;
    field_len     = '0;
    row_number    = '0;
    requests_sent = 0;
    gap_writes    = 0;
    foreach (rows_sent[c]) rows_sent[c] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty columns, then the first mark under the reset gap
    send_request(OP_LOOKUP, COL_W'(0), '0, '0);
    send_request(OP_LOOKUP, COL_W'(15), '1, '1);
    repeat (5) send_request(OP_APPEND, COL_W'(0), '1, $urandom);
    send_request(OP_APPEND, COL_W'(0), '0, '1);
    send_request(OP_LOOKUP, COL_W'(0), '0, ROW_W'(3));
    send_request(OP_LOOKUP, COL_W'(0), '0, ROW_W'(4));
    send_request(OP_LOOKUP, COL_W'(0), '0, '1);

    // zero gap: every append records a mark
    write_gap('0);
    send_request(OP_APPEND, COL_W'(15), '0, '0);
    send_request(OP_APPEND, COL_W'(15), '1, '0);
    send_request(OP_APPEND, COL_W'(15), '0, '1);
    send_request(OP_LOOKUP, COL_W'(15), '0, '0);
    send_request(OP_LOOKUP, COL_W'(15), '0, ROW_W'(1));
    send_request(OP_LOOKUP, COL_W'(15), '0, '1);
    send_request(OP_APPEND, COL_W'(0), LEN_W'(1234), $urandom);

    // largest gap
    write_gap('1);
    repeat (2) send_request(OP_APPEND, COL_W'(7), '1, $urandom);
    send_request(OP_LOOKUP, COL_W'(7), '0, ROW_W'(5));

    // fill one column until its mark table overflows
    write_gap(GAP_W'(1));
    send_request(OP_APPEND, COL_W'(FILL_COLUMN), '0, $urandom);
    while (rows_sent[FILL_COLUMN] < MARKS_PER_COLUMN + 4) begin
      if ($urandom_range(0, 63) == 0)
        send_request(OP_LOOKUP, COL_W'(FILL_COLUMN), LEN_W'($urandom),
                     ROW_W'($urandom_range(0, rows_sent[FILL_COLUMN])));
      else
        send_request(OP_APPEND, COL_W'(FILL_COLUMN), LEN_W'($urandom_range(1, 255)),
                     $urandom);
    end
    send_request(OP_LOOKUP, COL_W'(FILL_COLUMN), '0, '0);
    send_request(OP_LOOKUP, COL_W'(FILL_COLUMN), '0, '1);
    send_request(OP_LOOKUP, COL_W'(FILL_COLUMN), '0, ROW_W'(512));

    write_gap(GAP_W'($urandom_range(64, 4096)));
    squeeze <= 1'b1;
    repeat (60) random_request($urandom_range(0, MAX_COLUMNS - 1), 50, 60, 1'b0);

    write_gap(GAP_W'($urandom_range(65536, 1048575)));
    repeat (40) random_request($urandom_range(0, MAX_COLUMNS - 1), 40, 60, 1'b0);

    // no idling from here on, long fields at the largest gap
    calm <= 1'b1;
    write_gap('1);
    repeat (40) random_request(WIDE_COLUMN, 95, 90, 1'b1);

    in_valid <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d requests under %0d gap settings, %0d marks recorded, %0d dropped on a full table",
             requests_sent, gap_writes + 1, marks_made, marks_dropped);
    $display("lookups: %0d found a mark, %0d found none", rows_found, rows_missed);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
